// ===== src/bdsl_pkg.sv =====
// Shared types and constants for the button debounce / press detector.
package bdsl_pkg;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned NOW_W       = 32;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_FILTER_TIME = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LONG_TIME   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_LONG_EN     = 2'd2;

    // register reset values
    localparam logic [CFG_DATA_W-1:0] FILTER_TIME_RST = 16'd50;
    localparam logic [CFG_DATA_W-1:0] LONG_TIME_RST   = 16'd2000;
    localparam logic                  LONG_EN_RST     = 1'b0;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_SHORT = 2'd1,
        EV_LONG  = 2'd2
    } t_event;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] filter_time_ms;
        logic [CFG_DATA_W-1:0] long_time_ms;
        logic                  long_enabled;
    } t_cfg;

endpackage

// ===== src/bdsl_cfg.sv =====
// Configuration register file of the press detector.
module bdsl_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_wr,
    input  logic [bdsl_pkg::CFG_INDEX_W-1:0]  i_index,
    input  logic [bdsl_pkg::CFG_DATA_W-1:0]   i_data,
    output bdsl_pkg::t_cfg                    o_cfg
);

    bdsl_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.filter_time_ms <= bdsl_pkg::FILTER_TIME_RST;
            r_cfg.long_time_ms   <= bdsl_pkg::LONG_TIME_RST;
            r_cfg.long_enabled   <= bdsl_pkg::LONG_EN_RST;
        end else if (i_wr) begin
            case (i_index)
                bdsl_pkg::REG_FILTER_TIME: r_cfg.filter_time_ms <= i_data;
                bdsl_pkg::REG_LONG_TIME:   r_cfg.long_time_ms   <= i_data;
                bdsl_pkg::REG_LONG_EN:     r_cfg.long_enabled   <= i_data[0];
                default: ; // unknown index: dropped
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== src/bdsl_in_stage.sv =====
// Input register stage: captures one sample transaction per cycle unless a held sample is not yet taken downstream.
module bdsl_in_stage #(
    parameter int unsigned TIME_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_level,
    input  logic [bdsl_pkg::NOW_W-1:0] i_now_ms,
    input  logic                 i_take,     // downstream consumes the held sample
    output logic                 o_valid,
    output logic                 o_level,
    output logic [TIME_BITS-1:0] o_now
);

    logic                 r_valid;
    logic                 r_level;
    logic [TIME_BITS-1:0] r_now;
    logic                 n_valid;
    logic                 w_load;

    assign o_ready = !r_valid || i_take;
    assign w_load  = i_valid && o_ready;
    assign n_valid = w_load || (r_valid && !i_take);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // payload: no reset; time reduced/extended to TIME_BITS here
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_level <= i_level;
            r_now   <= TIME_BITS'(i_now_ms);
        end
    end

    assign o_valid = r_valid;
    assign o_level = r_level;
    assign o_now   = r_now;

endmodule

// ===== src/bdsl_core.sv =====
// Debounce state and short/long press evaluation for one sample.
module bdsl_core #(
    parameter int unsigned TIME_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  bdsl_pkg::t_cfg       i_cfg,
    input  logic                 i_step,
    input  logic                 i_level,
    input  logic [TIME_BITS-1:0] i_now,
    output bdsl_pkg::t_event     o_event
);

    logic                 r_prev_level;
    logic [TIME_BITS-1:0] r_change_time;
    logic                 r_short_done;
    logic                 r_long_done;

    logic                 n_prev_level;
    logic [TIME_BITS-1:0] n_change_time;
    logic                 n_short_done;
    logic                 n_long_done;

    logic [TIME_BITS-1:0] w_held;
    logic                 w_stable;
    logic                 w_long_due;
    bdsl_pkg::t_event     w_event;

    // wraps modulo 2^TIME_BITS
    assign w_held     = i_now - r_change_time;
    assign w_stable   = w_held >= TIME_BITS'(i_cfg.filter_time_ms);
    assign w_long_due = w_held >= TIME_BITS'(i_cfg.long_time_ms);

    always_comb begin
        n_short_done = r_short_done;
        n_long_done  = r_long_done;
        w_event      = bdsl_pkg::EV_NONE;
        if (w_stable) begin
            if (r_prev_level) begin
                n_short_done = 1'b0;
                n_long_done  = 1'b0;
            end else begin
                if (!r_short_done && (i_level || !i_cfg.long_enabled)) begin
                    n_short_done = 1'b1;
                    w_event      = bdsl_pkg::EV_SHORT;
                end
                // long overrides short in the same sample
                if (!r_long_done && w_long_due) begin
                    n_long_done  = 1'b1;
                    n_short_done = 1'b1;
                    w_event      = bdsl_pkg::EV_LONG;
                end
            end
        end
        n_change_time = (r_prev_level != i_level) ? i_now : r_change_time;
        n_prev_level  = i_level;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_level  <= 1'b1;
            r_change_time <= '0;
            r_short_done  <= 1'b0;
            r_long_done   <= 1'b0;
        end else if (i_step) begin
            r_prev_level  <= n_prev_level;
            r_change_time <= n_change_time;
            r_short_done  <= n_short_done;
            r_long_done   <= n_long_done;
        end
    end

    assign o_event = w_event;

endmodule

// ===== src/button_debounce_short_long_press.sv =====
// Top level of the button debounce with short/long press detection.
//
// Each input transaction carries one sample of an active-low button pin
// (i_level, 0 = pressed) and a free-running millisecond timestamp
// (i_now_ms). Every sample yields exactly one output transaction on
// o_press_event: 0 = nothing, 1 = short press, 2 = long press. Once the
// level has been stable for filter_time_ms, a released button re-arms
// detection; a held button reports short on release (or immediately when
// long_enabled is 0) and long once held for long_time_ms, long winning
// when both fire on the same sample. Time differences wrap modulo
// 2^TIME_BITS. Throughput is one sample per clock while the result side
// accepts; a sample passes the input register and then the result
// register, with the combinational evaluation of the debounce state
// between them. The result register frees the input side, so a new
// sample is taken while a result waits, and both sides stall cleanly
// under backpressure. Configuration registers (0 filter_time_ms,
// 1 long_time_ms, 2 long_enabled) are always ready and should be
// written only with no samples in flight; unknown indexes are ignored.
module button_debounce_short_long_press #(
    parameter int unsigned TIME_BITS = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // sample channel
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_level,
    input  logic [bdsl_pkg::NOW_W-1:0]        i_now_ms,
    // result channel
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [1:0]                        o_press_event,
    // configuration write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [bdsl_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [bdsl_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    bdsl_pkg::t_cfg       w_cfg;
    logic                 w_s1_valid;
    logic                 w_s1_level;
    logic [TIME_BITS-1:0] w_s1_now;
    logic                 w_step;
    logic                 w_out_free;
    bdsl_pkg::t_event     w_event;

    logic                 r_out_valid;
    bdsl_pkg::t_event     r_event;
    logic                 n_out_valid;

    assign o_cfg_ready = 1'b1;

    bdsl_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    // result register can load when empty or being drained this cycle
    assign w_out_free = !r_out_valid || i_out_ready;
    // a held sample is evaluated and the debounce state advances
    assign w_step     = w_s1_valid && w_out_free;

    bdsl_in_stage #(
        .TIME_BITS (TIME_BITS)
    ) u_in_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid),
        .o_ready  (o_in_ready),
        .i_level  (i_level),
        .i_now_ms (i_now_ms),
        .i_take   (w_step),
        .o_valid  (w_s1_valid),
        .o_level  (w_s1_level),
        .o_now    (w_s1_now)
    );

    bdsl_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_step  (w_step),
        .i_level (w_s1_level),
        .i_now   (w_s1_now),
        .o_event (w_event)
    );

    assign n_out_valid = w_step || (r_out_valid && !i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_event <= w_event;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_press_event = r_event;

endmodule

// ===== verif/button_debounce_short_long_press_tb.sv =====
// Self-checking testbench for the button debounce with short/long press detection.
`timescale 1ns / 1ps

// Tracks the debounce state and the expected press events, oldest first.
class press_scoreboard;
    logic [bdsl_pkg::CFG_DATA_W-1:0] filter_ms;
    logic [bdsl_pkg::CFG_DATA_W-1:0] long_ms;
    logic                            long_en;

    logic                            prev_lvl;
    logic [bdsl_pkg::NOW_W-1:0]      last_change_ms;
    logic                            short_seen;
    logic                            long_seen;

    bdsl_pkg::t_event                event_q[$];
    int                              errors;

    function new();
        filter_ms      = bdsl_pkg::FILTER_TIME_RST;
        long_ms        = bdsl_pkg::LONG_TIME_RST;
        long_en        = bdsl_pkg::LONG_EN_RST;
        prev_lvl       = 1'b1;
        last_change_ms = '0;
        short_seen     = 1'b0;
        long_seen      = 1'b0;
        errors         = 0;
    endfunction

    function void write_reg(logic [bdsl_pkg::CFG_INDEX_W-1:0] idx,
                            logic [bdsl_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            bdsl_pkg::REG_FILTER_TIME: filter_ms = data;
            bdsl_pkg::REG_LONG_TIME:   long_ms   = data;
            bdsl_pkg::REG_LONG_EN:     long_en   = data[0];
            default: ;  // unmapped index, dropped
        endcase
    endfunction

    // One accepted sample transaction -> exactly one expected event.
    function void note_sample(logic lvl, logic [bdsl_pkg::NOW_W-1:0] now_ms);
        logic [bdsl_pkg::NOW_W-1:0] held_ms;
        bdsl_pkg::t_event           ev;
        held_ms = now_ms - last_change_ms;  // wraps mod 2^32
        ev      = bdsl_pkg::EV_NONE;
        if (held_ms >= bdsl_pkg::NOW_W'(filter_ms)) begin
            if (prev_lvl) begin
                short_seen = 1'b0;
                long_seen  = 1'b0;
            end else begin
                if (!short_seen && (lvl || !long_en)) begin
                    short_seen = 1'b1;
                    ev         = bdsl_pkg::EV_SHORT;
                end
                if (!long_seen && held_ms >= bdsl_pkg::NOW_W'(long_ms)) begin
                    long_seen  = 1'b1;
                    short_seen = 1'b1;
                    ev         = bdsl_pkg::EV_LONG;
                end
            end
        end
        if (prev_lvl != lvl)
            last_change_ms = now_ms;
        prev_lvl = lvl;
        event_q.push_back(ev);
    endfunction

    function void check_event(logic [1:0] got);
        bdsl_pkg::t_event want;
        if (event_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected press event, expected none, actual %0d", $time, got);
        end else begin
            want = event_q.pop_front();
            if (got !== want) begin
                errors++;
                $display("%0t: press_event mismatch, expected %0d, actual %0d",
                         $time, want, got);
            end
        end
    endfunction

    function int pending();
        return event_q.size();
    endfunction
endclass

module button_debounce_short_long_press_tb;

    // index 3 decodes to no register; writes there must be dropped
    localparam logic [bdsl_pkg::CFG_INDEX_W-1:0] REG_SPARE = 2'd3;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned HOLD_OFF_CYCLES = 150;
    localparam int unsigned PHASE_ITEMS = 62;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_in_valid = 1'b0;
    logic                             o_in_ready;
    logic                             i_level = 1'b1;
    logic [bdsl_pkg::NOW_W-1:0]       i_now_ms = '0;
    logic                             o_out_valid;
    logic                             i_out_ready = 1'b0;
    logic [1:0]                       o_press_event;
    logic                             i_cfg_valid = 1'b0;
    logic                             o_cfg_ready;
    logic [bdsl_pkg::CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [bdsl_pkg::CFG_DATA_W-1:0]  i_cfg_data = '0;

    press_scoreboard sb = new();

    // idle odds in percent, per side; changed between phases
    int unsigned send_idle_pct = 37;
    int unsigned recv_idle_pct = 60;

    // receiver hold-off: main flow raises the request, receiver counts it down
    bit          hold_off_req = 1'b0;
    int unsigned hold_off_left = 0;

    int unsigned samples_sent = 0;
    int unsigned quiet_cycles = 0;
    logic [bdsl_pkg::NOW_W-1:0] clock_ms = '0;   // running millisecond time for sequences

    button_debounce_short_long_press dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_level       (i_level),
        .i_now_ms      (i_now_ms),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_press_event (o_press_event),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // 12 ns period
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Result side: check every accepted result transaction, then pick the
    // next ready. A pending hold-off keeps ready low for a long stretch.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready)
                sb.check_event(o_press_event);
            if (hold_off_req) begin
                hold_off_left = HOLD_OFF_CYCLES;
                hold_off_req  = 1'b0;
            end
            if (hold_off_left > 0) begin
                hold_off_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog: any accepted transaction on any channel restarts the count.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Offer one sample; random idle cycles go in front of it. Valid stays
    // high across back-to-back samples, only the payload moves.
    task automatic send_sample(input logic lvl, input logic [bdsl_pkg::NOW_W-1:0] stamp);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_level    <= lvl;
        i_now_ms   <= stamp;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_sample(lvl, stamp);
        samples_sent++;
    endtask

    // Advance the running time by up to max_step ms and sample.
    task automatic step_sample(input logic lvl, input int unsigned max_step);
        clock_ms = clock_ms + $urandom_range(0, max_step);
        send_sample(lvl, clock_ms);
    endtask

    // Stop offering samples, then wait until every expected event has come back.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    // Write all three registers back to back; optionally also poke the
    // unmapped index. Only called with nothing in flight.
    task automatic program_regs(input logic [bdsl_pkg::CFG_DATA_W-1:0] filt,
                                input logic [bdsl_pkg::CFG_DATA_W-1:0] hold,
                                input logic en, input bit poke_spare);
        logic [bdsl_pkg::CFG_INDEX_W-1:0] idx [4];
        logic [bdsl_pkg::CFG_DATA_W-1:0]  dat [4];
        int                               n;
        idx[0] = bdsl_pkg::REG_FILTER_TIME; dat[0] = filt;
        idx[1] = bdsl_pkg::REG_LONG_TIME;   dat[1] = hold;
        idx[2] = bdsl_pkg::REG_LONG_EN;     dat[2] = {15'($urandom), en};  // upper bits ignored
        n = 3;
        if (poke_spare) begin
            idx[3] = REG_SPARE;
            dat[3] = bdsl_pkg::CFG_DATA_W'($urandom);
            n = 4;
        end
        for (int k = 0; k < n; k++) begin
            if (k == 0)
                i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data  <= dat[k];
            do @(posedge i_clk); while (!o_cfg_ready);
            sb.write_reg(idx[k], dat[k]);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // A well-formed press: bounce, hold for a random time scaled to the
    // current filter/long settings, bounce on release, then rest released.
    task automatic press_episode();
        int unsigned span;
        int unsigned step_max;
        int unsigned hold_ms;
        int unsigned elapsed;
        int unsigned step;
        logic        lvl;
        span     = sb.filter_ms + sb.long_ms;
        step_max = span / 8 + 2;
        lvl      = 1'b0;
        repeat ($urandom_range(0, 3)) begin
            step_sample(lvl, step_max / 4);
            lvl = ~lvl;
        end
        hold_ms = $urandom_range(0, 2 * span + 10);
        elapsed = 0;
        do begin
            step = $urandom_range(1, step_max);
            clock_ms = clock_ms + step;
            elapsed += step;
            send_sample(1'b0, clock_ms);
        end while (elapsed < hold_ms);
        lvl = 1'b1;
        repeat ($urandom_range(0, 2)) begin
            step_sample(lvl, step_max / 4);
            lvl = ~lvl;
        end
        repeat ($urandom_range(1, 3))
            step_sample(1'b1, step_max * 2);
    endtask

    // Off-pattern samples: random stamps, big jumps, repeats, glitches.
    task automatic noise_sample();
        case ($urandom_range(0, 3))
            0: send_sample(1'($urandom), $urandom());
            1: begin
                clock_ms = clock_ms + $urandom();
                send_sample(1'($urandom), clock_ms);
            end
            2: send_sample(1'($urandom), clock_ms);
            default: step_sample(~i_level, 2);
        endcase
    endtask

    // Mostly press sequences with random content, some noise. If asked,
    // the receiver hold-off starts partway in while samples keep coming.
    task automatic run_phase(input int unsigned n_items, input bit with_hold_off);
        int unsigned stop_at;
        int unsigned hold_at;
        stop_at = samples_sent + n_items;
        hold_at = samples_sent + n_items / 3;
        while (samples_sent < stop_at) begin
            if (with_hold_off && samples_sent >= hold_at) begin
                hold_off_req  = 1'b1;
                with_hold_off = 1'b0;
            end
            if ($urandom_range(99) < 80)
                press_episode();
            else
                noise_sample();
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- directed part, reset settings: filter 50, long 2000, long off
        send_sample(1'b1, 32'd0);              // too soon after reset: nothing
        send_sample(1'b0, 32'd100);            // released & stable: re-arm, press edge
        send_sample(1'b0, 32'd120);            // still inside filter window
        send_sample(1'b0, 32'd150);            // long off: short fires at once
        send_sample(1'b0, 32'd2100);           // held 2000: long press
        send_sample(1'b1, 32'd2200);           // release after long: nothing
        send_sample(1'b1, 32'hFFFF_FFFF);      // all-ones stamp, re-arm
        send_sample(1'b0, 32'hFFFF_FFF0);      // press just before wrap
        send_sample(1'b0, 32'h0000_0030);      // held across wrap: short
        send_sample(1'b1, 32'h0000_0040);

        // zero filter and zero long time, long enabled
        drain();
        program_regs(16'd0, 16'd0, 1'b1, 1'b1);
        send_sample(1'b0, 32'd1000);           // re-arm, press edge
        send_sample(1'b0, 32'd1000);           // held 0 >= 0: long right away
        send_sample(1'b1, 32'd1000);           // both done: nothing

        // top of range: short on release and long in the same sample
        drain();
        program_regs(16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
        send_sample(1'b1, 32'd0);
        send_sample(1'b0, 32'd10);
        send_sample(1'b0, 32'd65544);          // one ms short of the filter
        send_sample(1'b1, 32'd65545);          // both fire, long wins

        // long enabled: short waits for release
        drain();
        program_regs(16'd20, 16'd100, 1'b1, 1'b1);
        send_sample(1'b0, 32'd70000);
        send_sample(1'b0, 32'd70050);          // long pending, short held back
        send_sample(1'b1, 32'd70060);          // release: short
        send_sample(1'b1, 32'd70061);          // inside filter after release
        send_sample(1'b1, 32'd70100);          // stable released: re-arm

        // ---- random part; sender idles 37%, receiver 60%
        drain();
        program_regs(16'($urandom_range(0, 40)), 16'($urandom_range(50, 300)), 1'b1, 1'b1);
        clock_ms = $urandom();
        run_phase(PHASE_ITEMS, 1'b0);

        drain();
        program_regs(16'd10, 16'd200, 1'b0, 1'b0);
        run_phase(PHASE_ITEMS, 1'b1);          // long receiver hold-off in here

        // sender idles 60%, receiver 37%
        send_idle_pct = 60;
        recv_idle_pct = 37;
        drain();
        program_regs(16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
        run_phase(PHASE_ITEMS, 1'b0);

        drain();
        program_regs(16'd0, 16'd0, 1'b0, 1'b1);
        run_phase(PHASE_ITEMS, 1'b0);

        // no idling on either side
        send_idle_pct = 0;
        recv_idle_pct = 0;
        drain();
        program_regs(16'($urandom), 16'($urandom), 1'($urandom), 1'b0);
        run_phase(PHASE_ITEMS, 1'b0);

        drain();
        program_regs(16'($urandom_range(0, 20)), 16'($urandom_range(0, 100)),
                     1'($urandom), 1'b1);
        clock_ms = 32'hFFFF_FF80;              // sequences run through the wrap
        run_phase(PHASE_ITEMS, 1'b0);

        drain();
        // let the clock run on so a stray extra result would still be caught
        repeat (8) @(posedge i_clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
